// ===== design/sgb_pkg.sv =====
// shared types, constants and field layouts for the spatial grid binning histogram
package sgb_pkg;

    // default store geometry
    localparam int MAX_CELLS_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 16;

    // field widths
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 24;
    localparam int STATUS_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE    = 2'd2;

    // configuration reset values
    localparam logic [REG_W-1:0] EXTENT_ROWS_RST = 16'd512;
    localparam logic [REG_W-1:0] EXTENT_COLS_RST = 16'd512;
    localparam logic [REG_W-1:0] BIN_SIZE_RST    = 16'd16;

    // item kinds
    localparam logic KIND_BIN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // shared divider geometry: 32 / 16 with a 16 bit quotient
    localparam int DIVIDEND_W    = 32;
    localparam int QUO_W         = 16;
    localparam int DIV_BITS_STEP = 4;
    localparam int DIV_CYCLES    = QUO_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
    localparam int PROD_W        = 32;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OUTSIDE   = 2'd1,
        STATUS_BAD_INDEX = 2'd2,
        STATUS_GRID      = 2'd3
    } status_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] row_coord;
        logic [COORD_W-1:0] col_coord;
        logic [INDEX_W-1:0] cell_index;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cell_count;
        logic [INDEX_W-1:0] target_cell;
        logic [TOTAL_W-1:0] total_points;
        status_t            status;
    } result_t;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [QUO_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/spatial_grid_binning_histogram.sv =====
// top level: sequencer, shared multiplier, count store and result register
//
// Bins 2D points into a grid of cells and keeps a saturating count per cell.
// Items arrive on item/item_valid/item_stall: kind 0 bins a point given by
// row_coord and col_coord, kind 1 reads the count at cell_index. Each item
// gives exactly one beat on result/result_valid/result_stall carrying the
// cell count, the cell index, the running total and a status code.
// Configuration (extent_rows, extent_cols, bin_size) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no item is in
// flight, as the block itself does not enforce this. The first item after a
// configuration write first derives the grid size. Both coordinate
// divisions and both ceiling divisions go through one shared divider that
// retires 4 quotient bits per cycle; item_stall stays high while an item is
// being worked on, so a new item is taken only once the last one is done.
// After reset the count store is cleared, one entry per cycle, over all
// MAX_CELLS entries; item_stall is high during that pass. A finished result
// waits in the output register while the receiver stalls, and the next item
// may be taken meanwhile; it then holds in its last step until the register
// is free.
module spatial_grid_binning_histogram #(
    parameter int MAX_CELLS  = sgb_pkg::MAX_CELLS_DEF,
    parameter int COUNT_BITS = sgb_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sgb_pkg::REG_W-1:0]       cfg_data,
    // item channel
    input  logic                            item_valid,
    output logic                            item_stall,
    input  sgb_pkg::item_t                  item,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output sgb_pkg::result_t                result
);

    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam int CELL_W = $clog2(MAX_CELLS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_GISSUE = 15'b000000000000100,
        S_GWAIT  = 15'b000000000001000,
        S_GMUL   = 15'b000000000010000,
        S_GCHK   = 15'b000000000100000,
        S_CHECK  = 15'b000000001000000,
        S_CMUL   = 15'b000000010000000,
        S_CISSUE = 15'b000000100000000,
        S_CWAIT  = 15'b000001000000000,
        S_IMUL   = 15'b000010000000000,
        S_IADD   = 15'b000100000000000,
        S_READ   = 15'b001000000000000,
        S_RDATA  = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [ADDR_W-1:0]                clr_addr_reg, clr_addr_next;
    logic [sgb_pkg::REG_W-1:0]        er_reg, er_next;
    logic [sgb_pkg::REG_W-1:0]        ec_reg, ec_next;
    logic [sgb_pkg::REG_W-1:0]        bs_reg, bs_next;
    logic                             grid_valid_reg, grid_valid_next;
    logic                             grid_bad_reg, grid_bad_next;
    logic                             axis_reg, axis_next;
    logic [sgb_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic                             result_valid_reg, result_valid_next;
    logic [sgb_pkg::QUO_W-1:0]        g1_reg, g1_next;
    logic [sgb_pkg::QUO_W-1:0]        g2_reg, g2_next;
    logic [CELL_W-1:0]                cells_reg, cells_next;
    sgb_pkg::item_t                   item_reg, item_next;
    logic [sgb_pkg::QUO_W-1:0]        r_reg, r_next;
    logic [sgb_pkg::QUO_W-1:0]        c_reg, c_next;
    logic [ADDR_W-1:0]                idx_reg, idx_next;
    sgb_pkg::status_t                 status_reg, status_next;
    logic [COUNT_BITS-1:0]            res_count_reg, res_count_next;
    logic [sgb_pkg::INDEX_W-1:0]      res_target_reg, res_target_next;
    sgb_pkg::result_t                 result_reg, result_next;
    logic [sgb_pkg::PROD_W-1:0]       mul_reg;

    logic [sgb_pkg::QUO_W-1:0]        mul_a, mul_b;
    sgb_pkg::div_req_t                div_req;
    sgb_pkg::div_rsp_t                div_rsp;
    logic                             grid_zero;
    logic [sgb_pkg::REG_W:0]          ceil_num;
    logic [sgb_pkg::PROD_W-1:0]       cells_wide;
    logic [sgb_pkg::PROD_W-1:0]       max_wide;
    logic [sgb_pkg::PROD_W-1:0]       ci_wide;
    logic [sgb_pkg::PROD_W-1:0]       idx_sum;
    logic [sgb_pkg::PROD_W-1:0]       idx_wide;
    logic [sgb_pkg::PROD_W-1:0]       count_wide;
    logic                             ram_we;
    logic [ADDR_W-1:0]                ram_waddr;
    logic [COUNT_BITS-1:0]            ram_wdata;
    logic [COUNT_BITS-1:0]            ram_rdata;
    logic [COUNT_BITS-1:0]            count_inc;

    // count store
    sgb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_CELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // shared divider
    sgb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // helper values
    assign grid_zero  = (er_reg == '0) || (ec_reg == '0) || (bs_reg == '0);
    assign ceil_num   = (axis_reg ? {1'b0, ec_reg} : {1'b0, er_reg}) + {1'b0, bs_reg}
                        - (sgb_pkg::REG_W + 1)'(1);
    assign cells_wide = sgb_pkg::PROD_W'(cells_reg);
    assign max_wide   = sgb_pkg::PROD_W'(MAX_CELLS);
    assign ci_wide    = sgb_pkg::PROD_W'(item_reg.cell_index);
    assign idx_sum    = mul_reg + sgb_pkg::PROD_W'(c_reg);
    assign idx_wide   = sgb_pkg::PROD_W'(idx_reg);
    assign count_wide = sgb_pkg::PROD_W'(res_count_reg);
    assign count_inc  = (ram_rdata != COUNT_MAX) ? ram_rdata + COUNT_BITS'(1) : ram_rdata;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GMUL:
            begin
                mul_a = g1_reg;
                mul_b = g2_reg;
            end
            S_CMUL:
            begin
                mul_a = axis_reg ? item_reg.col_coord : item_reg.row_coord;
                mul_b = axis_reg ? g2_reg : g1_reg;
            end
            S_IMUL:
            begin
                mul_a = r_reg;
                mul_b = g2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request
    always_comb
    begin
        div_req.start    = ((state_reg == S_GISSUE) && !grid_zero) || (state_reg == S_CISSUE);
        div_req.dividend = (state_reg == S_GISSUE) ? sgb_pkg::DIVIDEND_W'(ceil_num) : mul_reg;
        div_req.divisor  = (state_reg == S_GISSUE) ? bs_reg : (axis_reg ? ec_reg : er_reg);
    end

    // store write port: clearing pass or count update
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = count_inc;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if ((state_reg == S_RDATA) && (item_reg.kind == sgb_pkg::KIND_BIN))
        begin
            ram_we = 1'b1;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        er_next           = er_reg;
        ec_next           = ec_reg;
        bs_next           = bs_reg;
        grid_valid_next   = grid_valid_reg;
        grid_bad_next     = grid_bad_reg;
        axis_next         = axis_reg;
        total_next        = total_reg;
        result_valid_next = result_valid_reg;
        g1_next           = g1_reg;
        g2_next           = g2_reg;
        cells_next        = cells_reg;
        item_next         = item_reg;
        r_next            = r_reg;
        c_next            = c_reg;
        idx_next          = idx_reg;
        status_next       = status_reg;
        res_count_next    = res_count_reg;
        res_target_next   = res_target_reg;
        result_next       = result_reg;

        // result register drains on a taken beat
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAX_CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    axis_next  = 1'b0;
                    state_next = grid_valid_reg ? S_CHECK : S_GISSUE;
                end
            end
            S_GISSUE:
            begin
                if (grid_zero)
                begin
                    grid_bad_next   = 1'b1;
                    grid_valid_next = 1'b1;
                    state_next      = S_CHECK;
                end
                else
                begin
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!axis_reg)
                    begin
                        g1_next    = div_rsp.quotient;
                        axis_next  = 1'b1;
                        state_next = S_GISSUE;
                    end
                    else
                    begin
                        g2_next    = div_rsp.quotient;
                        axis_next  = 1'b0;
                        state_next = S_GMUL;
                    end
                end
            end
            S_GMUL:
            begin
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                grid_bad_next   = (mul_reg > max_wide);
                cells_next      = CELL_W'(mul_reg);
                grid_valid_next = 1'b1;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                status_next     = sgb_pkg::STATUS_OK;
                res_count_next  = '0;
                res_target_next = '0;
                if (grid_bad_reg)
                begin
                    status_next = sgb_pkg::STATUS_GRID;
                    state_next  = S_FIN;
                end
                else if (item_reg.kind == sgb_pkg::KIND_READ)
                begin
                    if ((ci_wide >= cells_wide) || (ci_wide >= max_wide))
                    begin
                        status_next = sgb_pkg::STATUS_BAD_INDEX;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        idx_next   = ci_wide[ADDR_W-1:0];
                        state_next = S_READ;
                    end
                end
                else if ((item_reg.row_coord >= er_reg) || (item_reg.col_coord >= ec_reg))
                begin
                    status_next = sgb_pkg::STATUS_OUTSIDE;
                    state_next  = S_FIN;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                state_next = S_CISSUE;
            end
            S_CISSUE:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (!axis_reg)
                    begin
                        r_next     = div_rsp.quotient;
                        axis_next  = 1'b1;
                        state_next = S_CMUL;
                    end
                    else
                    begin
                        c_next     = div_rsp.quotient;
                        axis_next  = 1'b0;
                        state_next = S_IMUL;
                    end
                end
            end
            S_IMUL:
            begin
                state_next = S_IADD;
            end
            S_IADD:
            begin
                if ((idx_sum >= cells_wide) || (idx_sum >= max_wide))
                begin
                    status_next = sgb_pkg::STATUS_BAD_INDEX;
                    state_next  = S_FIN;
                end
                else
                begin
                    idx_next   = idx_sum[ADDR_W-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                res_target_next = idx_wide[sgb_pkg::INDEX_W-1:0];
                if (item_reg.kind == sgb_pkg::KIND_BIN)
                begin
                    res_count_next = count_inc;
                    if (total_reg != sgb_pkg::TOTAL_MAX)
                    begin
                        total_next = total_reg + sgb_pkg::TOTAL_W'(1);
                    end
                end
                else
                begin
                    res_count_next = ram_rdata;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.cell_count   = count_wide[sgb_pkg::COUNT_W-1:0];
                    result_next.target_cell  = res_target_reg;
                    result_next.total_points = total_reg;
                    result_next.status       = status_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes, grid size is derived again on the next item
        if (cfg_we)
        begin
            case (cfg_index)
                sgb_pkg::REG_EXTENT_ROWS:
                begin
                    er_next         = cfg_data;
                    grid_valid_next = 1'b0;
                    grid_bad_next   = 1'b0;
                end
                sgb_pkg::REG_EXTENT_COLS:
                begin
                    ec_next         = cfg_data;
                    grid_valid_next = 1'b0;
                    grid_bad_next   = 1'b0;
                end
                sgb_pkg::REG_BIN_SIZE:
                begin
                    bs_next         = cfg_data;
                    grid_valid_next = 1'b0;
                    grid_bad_next   = 1'b0;
                end
                default:
                begin
                    er_next = er_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            er_reg           <= sgb_pkg::EXTENT_ROWS_RST;
            ec_reg           <= sgb_pkg::EXTENT_COLS_RST;
            bs_reg           <= sgb_pkg::BIN_SIZE_RST;
            grid_valid_reg   <= 1'b0;
            grid_bad_reg     <= 1'b0;
            axis_reg         <= 1'b0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            er_reg           <= er_next;
            ec_reg           <= ec_next;
            bs_reg           <= bs_next;
            grid_valid_reg   <= grid_valid_next;
            grid_bad_reg     <= grid_bad_next;
            axis_reg         <= axis_next;
            total_reg        <= total_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers and shared multiplier
    always_ff @(posedge clk)
    begin
        g1_reg         <= g1_next;
        g2_reg         <= g2_next;
        cells_reg      <= cells_next;
        item_reg       <= item_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        res_count_reg  <= res_count_next;
        res_target_reg <= res_target_next;
        result_reg     <= result_next;
        mul_reg        <= sgb_pkg::PROD_W'(mul_a) * sgb_pkg::PROD_W'(mul_b);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // divider is never started with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divider started with zero divisor");

    // a new result beat only comes out of the final step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final step");

    // no item is taken during the clearing pass
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> item_stall)
        else $error("item accepted while clearing store");

    // the total only ever steps up by one
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |->
            (total_reg == $past(total_reg) + sgb_pkg::TOTAL_W'(1)))
        else $error("total changed by other than one");

endmodule

// ===== design/sgb_ram.sv =====
// generic single write port, single read port ram with registered read
module sgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sgb_div.sv =====
// iterative restoring divider, 32 by 16 bits, DIV_BITS_STEP quotient bits per cycle
module sgb_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sgb_pkg::div_req_t req,
    output sgb_pkg::div_rsp_t rsp
);

    logic [sgb_pkg::QUO_W-1:0]     rem_reg, rem_next;
    logic [sgb_pkg::QUO_W-1:0]     dvd_reg, dvd_next;
    logic [sgb_pkg::QUO_W-1:0]     dvs_reg;
    logic [sgb_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    // DIV_BITS_STEP shift and subtract steps, taken together in each cycle
    always_comb
    begin
        logic [sgb_pkg::QUO_W:0] trial;
        logic                    qbit;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int i = 0; i < sgb_pkg::DIV_BITS_STEP; i++)
        begin
            trial = {rem_next, dvd_next[sgb_pkg::QUO_W-1]};
            qbit  = (trial >= {1'b0, dvs_reg});
            if (qbit)
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            rem_next = trial[sgb_pkg::QUO_W-1:0];
            dvd_next = {dvd_next[sgb_pkg::QUO_W-2:0], qbit};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + sgb_pkg::DIV_CNT_W'(1);
                if (cnt_reg == sgb_pkg::DIV_CNT_W'(sgb_pkg::DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, high dividend half must be below the divisor
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[sgb_pkg::DIVIDEND_W-1:sgb_pkg::QUO_W];
            dvd_reg <= req.dividend[sgb_pkg::QUO_W-1:0];
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ===== verif/histogram_checker.sv =====
// checker for the grid binning histogram: tracks cell counts and compares every result beat
`timescale 1ns / 1ps

module histogram_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgb_pkg::REG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  sgb_pkg::item_t                item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  sgb_pkg::result_t              result,
    output int                            fail_count,
    output int                            results_owed
);

    localparam int CELL_SLOTS = sgb_pkg::MAX_CELLS_DEF;
    localparam logic [sgb_pkg::COUNT_W-1:0] COUNT_TOP = {sgb_pkg::COUNT_W{1'b1}};

    // shadow of the block's registers and store
    logic [sgb_pkg::REG_W-1:0]   ext_rows;
    logic [sgb_pkg::REG_W-1:0]   ext_cols;
    logic [sgb_pkg::REG_W-1:0]   bin_sz;
    logic [sgb_pkg::COUNT_W-1:0] cell_tally [CELL_SLOTS];
    logic [sgb_pkg::TOTAL_W-1:0] point_total;

    sgb_pkg::result_t expected_cell_q [$];
    int               mismatches = 0;

    assign fail_count = mismatches;

    // works out the result beat of one item and updates the shadow store
    function automatic sgb_pkg::result_t predict_cell_result(input sgb_pkg::item_t it);
        sgb_pkg::result_t r;
        longint unsigned  g_rows;
        longint unsigned  g_cols;
        longint unsigned  n_cells;
        longint unsigned  row_cell;
        longint unsigned  col_cell;
        longint unsigned  flat;
        r        = '0;
        r.status = sgb_pkg::STATUS_OK;
        n_cells  = 0;
        g_rows   = 0;
        g_cols   = 0;

        // grid geometry comes first: zero registers or an oversized grid
        if (ext_rows == '0 || ext_cols == '0 || bin_sz == '0)
        begin
            r.status = sgb_pkg::STATUS_GRID;
        end
        else
        begin
            g_rows  = (64'(ext_rows) + 64'(bin_sz) - 1) / 64'(bin_sz);
            g_cols  = (64'(ext_cols) + 64'(bin_sz) - 1) / 64'(bin_sz);
            n_cells = g_rows * g_cols;
            if (n_cells > CELL_SLOTS)
                r.status = sgb_pkg::STATUS_GRID;
        end

        if (r.status == sgb_pkg::STATUS_OK)
        begin
            if (it.kind == sgb_pkg::KIND_BIN)
            begin
                if (it.row_coord >= ext_rows || it.col_coord >= ext_cols)
                begin
                    r.status = sgb_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    row_cell = (64'(it.row_coord) * g_rows) / 64'(ext_rows);
                    col_cell = (64'(it.col_coord) * g_cols) / 64'(ext_cols);
                    flat     = row_cell * g_cols + col_cell;
                    if (flat >= n_cells)
                    begin
                        r.status = sgb_pkg::STATUS_BAD_INDEX;
                    end
                    else
                    begin
                        // cell count and total both saturate
                        if (cell_tally[flat] != COUNT_TOP)
                            cell_tally[flat] = cell_tally[flat] + sgb_pkg::COUNT_W'(1);
                        if (point_total != sgb_pkg::TOTAL_MAX)
                            point_total = point_total + sgb_pkg::TOTAL_W'(1);
                        r.cell_count  = cell_tally[flat];
                        r.target_cell = sgb_pkg::INDEX_W'(flat);
                    end
                end
            end
            else
            begin
                if (64'(it.cell_index) >= n_cells)
                begin
                    r.status = sgb_pkg::STATUS_BAD_INDEX;
                end
                else
                begin
                    r.cell_count  = cell_tally[it.cell_index];
                    r.target_cell = it.cell_index;
                end
            end
        end

        r.total_points = point_total;
        return r;
    endfunction

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // follow config writes, predict on item beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin : track
        sgb_pkg::result_t want;
        if (!rst_n)
        begin
            ext_rows    = sgb_pkg::EXTENT_ROWS_RST;
            ext_cols    = sgb_pkg::EXTENT_COLS_RST;
            bin_sz      = sgb_pkg::BIN_SIZE_RST;
            point_total = '0;
            for (int i = 0; i < CELL_SLOTS; i++)
                cell_tally[i] = '0;
            expected_cell_q.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sgb_pkg::REG_EXTENT_ROWS: ext_rows = cfg_data;
                    sgb_pkg::REG_EXTENT_COLS: ext_cols = cfg_data;
                    sgb_pkg::REG_BIN_SIZE:    bin_sz   = cfg_data;
                    default: ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (expected_cell_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_cell_q.pop_front();
                    check_field("cell_count", want.cell_count, result.cell_count);
                    check_field("target_cell", want.target_cell, result.target_cell);
                    check_field("total_points", want.total_points, result.total_points);
                    check_field("status", want.status, result.status);
                end
            end

            // queue the predicted beat at the tail
            if (item_valid && !item_stall)
            begin
                want = predict_cell_result(item);
                expected_cell_q.insert(expected_cell_q.size(), want);
            end

            results_owed <= expected_cell_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the grid binning histogram: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_CYCLES     = 600;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CELL_SLOTS      = sgb_pkg::MAX_CELLS_DEF;
    localparam int COORD_TOP       = (1 << sgb_pkg::COORD_W) - 1;
    localparam int INDEX_TOP       = (1 << sgb_pkg::INDEX_W) - 1;
    // index with no register behind it
    localparam logic [sgb_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sgb_pkg::REG_W-1:0]     cfg_data;
    logic                          item_valid;
    logic                          item_stall;
    sgb_pkg::item_t                item;
    logic                          result_valid;
    logic                          result_stall;
    sgb_pkg::result_t              result;
    int                            fail_count;
    int                            results_owed;

    int     cycles      = 0;
    bit     hold_off    = 1'b0;
    bit     steady_send = 1'b0;
    // stimulus-side view of the current grid
    int     grid_rows_ext;
    int     grid_cols_ext;
    longint grid_cells;
    int     hot_row;
    int     hot_col;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spatial_grid_binning_histogram u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    histogram_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: open runs, short and long stalls, one long hold-off on request
    initial
    begin : receiver
        int pick;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    result_stall <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
                else if (pick < 90)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
                else
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (steady_send)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 100);
    endfunction

    // unused fields carry random bits
    function automatic sgb_pkg::item_t bin_item(input int row, input int col);
        sgb_pkg::item_t it;
        it.kind       = sgb_pkg::KIND_BIN;
        it.row_coord  = sgb_pkg::COORD_W'(row);
        it.col_coord  = sgb_pkg::COORD_W'(col);
        it.cell_index = sgb_pkg::INDEX_W'($urandom_range(0, INDEX_TOP));
        return it;
    endfunction

    function automatic sgb_pkg::item_t read_item(input int idx);
        sgb_pkg::item_t it;
        it.kind       = sgb_pkg::KIND_READ;
        it.row_coord  = sgb_pkg::COORD_W'($urandom_range(0, COORD_TOP));
        it.col_coord  = sgb_pkg::COORD_W'($urandom_range(0, COORD_TOP));
        it.cell_index = sgb_pkg::INDEX_W'(idx);
        return it;
    endfunction

    // offer one beat, hold it until taken, then maybe idle
    task automatic send_item(input sgb_pkg::item_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every owed result has come back and the block is quiet
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sgb_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= sgb_pkg::REG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input int ext_r, input int ext_c, input int bsz);
        longint g_r;
        longint g_c;
        write_reg(sgb_pkg::REG_EXTENT_ROWS, ext_r);
        write_reg(sgb_pkg::REG_EXTENT_COLS, ext_c);
        write_reg(sgb_pkg::REG_BIN_SIZE, bsz);
        grid_rows_ext = ext_r;
        grid_cols_ext = ext_c;
        if (ext_r == 0 || ext_c == 0 || bsz == 0)
        begin
            grid_cells = -1;
        end
        else
        begin
            g_r        = (ext_r + bsz - 1) / bsz;
            g_c        = (ext_c + bsz - 1) / bsz;
            grid_cells = g_r * g_c;
        end
        hot_row = 0;
        hot_col = 0;
    endtask

    // mostly constructed grids that fit the store, now and then anything
    task automatic pick_grid();
        int mode;
        int bsz;
        int gr;
        int gc;
        int span;
        int gr_max;
        int gc_max;
        int er;
        int ec;
        mode = $urandom_range(0, 7);
        if (mode == 0)
        begin
            set_grid($urandom_range(1, COORD_TOP), $urandom_range(1, COORD_TOP),
                     $urandom_range(1, COORD_TOP));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: bsz = $urandom_range(1, 8);
                1: bsz = $urandom_range(9, 256);
                2: bsz = $urandom_range(257, COORD_TOP);
                default: bsz = 16;
            endcase
            span   = (COORD_TOP + bsz - 1) / bsz;
            gr_max = (span < 64) ? span : 64;
            gr     = $urandom_range(1, gr_max);
            gc_max = (span < CELL_SLOTS / gr) ? span : CELL_SLOTS / gr;
            gc     = $urandom_range(1, gc_max);
            er     = $urandom_range((gr - 1) * bsz + 1,
                                    (gr * bsz < COORD_TOP) ? gr * bsz : COORD_TOP);
            ec     = $urandom_range((gc - 1) * bsz + 1,
                                    (gc * bsz < COORD_TOP) ? gc * bsz : COORD_TOP);
            set_grid(er, ec, bsz);
        end
    endtask

    // mostly points inside the extent, with repeats on a hot cell, plus reads
    task automatic run_random(input int n);
        int p;
        bit usable;
        for (int i = 0; i < n; i++)
        begin
            p      = $urandom_range(0, 99);
            usable = grid_cells > 0;
            if (p < 55 && usable)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    hot_row = $urandom_range(0, grid_rows_ext - 1);
                    hot_col = $urandom_range(0, grid_cols_ext - 1);
                end
                send_item(bin_item(hot_row, hot_col));
            end
            else if (p < 65)
            begin
                send_item(bin_item($urandom_range(0, COORD_TOP),
                                   $urandom_range(0, COORD_TOP)));
            end
            else if (p < 90 && usable && grid_cells <= CELL_SLOTS)
            begin
                send_item(read_item($urandom_range(0, int'(grid_cells) - 1)));
            end
            else
            begin
                send_item(read_item($urandom_range(0, INDEX_TOP)));
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        item       <= '0;
        grid_rows_ext = sgb_pkg::EXTENT_ROWS_RST;
        grid_cols_ext = sgb_pkg::EXTENT_COLS_RST;
        grid_cells    = 1024;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry, 32 by 32 cells: corners, points outside, reads
        send_item(bin_item(0, 0));
        send_item(bin_item(511, 511));
        send_item(bin_item(512, 0));
        send_item(bin_item(0, 512));
        send_item(bin_item(COORD_TOP, COORD_TOP));
        send_item(bin_item(255, 17));
        send_item(bin_item(255, 17));
        send_item(read_item(0));
        send_item(read_item(1023));
        send_item(read_item(15 * 32 + 1));
        send_item(read_item(1024));
        send_item(read_item(INDEX_TOP));
        drain();

        // grid that fills the store exactly
        set_grid(64, 64, 1);
        send_item(bin_item(63, 63));
        send_item(read_item(INDEX_TOP));
        send_item(read_item(0));
        drain();

        // widest registers give a single cell
        set_grid(COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(bin_item(COORD_TOP - 1, COORD_TOP - 1));
        send_item(bin_item(COORD_TOP, 0));
        send_item(read_item(0));
        send_item(read_item(1));
        drain();

        // tall single-column grid
        set_grid(COORD_TOP, 1, 16);
        send_item(bin_item(COORD_TOP - 1, 0));
        send_item(read_item(INDEX_TOP));
        drain();

        // zero bin size and zero extent leave the grid unusable
        set_grid(COORD_TOP, 1, 0);
        send_item(bin_item(3, 0));
        send_item(read_item(0));
        drain();
        set_grid(0, 512, 16);
        send_item(bin_item(0, 0));
        drain();

        // grid larger than the store
        set_grid(COORD_TOP, COORD_TOP, 1);
        send_item(bin_item(5, 5));
        send_item(read_item(0));
        drain();

        // a write to the spare index must leave the grid alone
        write_reg(REG_SPARE, $urandom_range(0, COORD_TOP));
        send_item(read_item(0));
        drain();

        // random phases, each under its own grid
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pick_grid();
            steady_send = (ph == 2 || ph == 5 || ph == 11);
            if (ph == 2)
                hold_off = 1'b1;
            run_random(ITEMS_PER_PHASE);
            drain();
        end
        steady_send = 1'b0;

        if (fail_count == 0 && results_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
